// ----- hw/rtl/cwpd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cwpd_pkg
// Types, constants and the CRC-8 byte update shared by the word pair deframer.
// ----------------------------------------------------------------------------
package cwpd_pkg;

	localparam int unsigned MAX_VALUES = 10;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// Byte position within one 32-bit value: two triplets of data, data, crc.
	localparam logic [2:0] PH_DATA0_A = 3'd0;
	localparam logic [2:0] PH_DATA1_A = 3'd1;
	localparam logic [2:0] PH_CRC_A   = 3'd2;
	localparam logic [2:0] PH_DATA0_B = 3'd3;
	localparam logic [2:0] PH_DATA1_B = 3'd4;
	localparam logic [2:0] PH_CRC_B   = 3'd5;

	// Register indexes of the configuration port.
	localparam logic REG_VALUE_COUNT = 1'b0;

	localparam logic [3:0] VALUE_COUNT_RESET = 4'd10;
	localparam logic [3:0] VALUE_COUNT_MAX   = 4'(MAX_VALUES);

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_t;

	typedef struct packed {
		logic [3:0]  value_index;
		logic [31:0] value;
		logic        words_ok;
		logic        frame_ok;
		logic        last;
	} out_t;

	// Feed one byte MSB first through the CRC-8.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/crc_checked_word_pair_deframer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crc_checked_word_pair_deframer
// Checks CRC-8 protected byte triplets and assembles 32-bit values per frame.
// ----------------------------------------------------------------------------
// Path: a byte that completes a value passes the input register, then the
//   result register, which presents its result.
// Throughput: one byte per cycle; the byte-wide CRC update and the framing
//   counters settle combinationally between the input and result registers.
//   A value byte holds in the input register while a result waits unread.
// Reset: arst_n clears the pipeline, sets value_count to 10 and leaves the
//   deframer idle until a byte marked as frame start arrives.
// ----------------------------------------------------------------------------
module crc_checked_word_pair_deframer
	import cwpd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_t         in_data,

	output logic             out_valid,
	input  wire logic        out_ready,
	output out_t             out_data,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [3:0] value_count_q;
	logic       reg_index;

	assign pready    = 1'b1;
	assign reg_index = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_count_q <= VALUE_COUNT_RESET;
		end else if (psel && penable && pwrite && reg_index == REG_VALUE_COUNT) begin
			value_count_q <= pwdata[3:0];
		end
	end

	always_comb begin
		case (reg_index)
			REG_VALUE_COUNT: prdata = {28'd0, value_count_q};
			default:         prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------
	logic valid_s1;
	in_t  item_s1;
	logic advance_s1;
	logic emit;
	logic out_free;

	// The result slot is free when empty or being drained this cycle.
	assign out_free   = !out_valid || out_ready;
	// Advance the held byte unless it carries a result that cannot land yet.
	assign advance_s1 = valid_s1 && (!emit || out_free);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// ------------------------------------------------------------------
	// Framing state
	// ------------------------------------------------------------------
	logic [2:0]  phase_q;
	logic [3:0]  counter_q;
	logic [7:0]  crc_q;
	logic [31:0] shift_q;
	logic        value_good_q;
	logic        frame_good_q;
	logic        frame_done_q;

	// Frame start restarts every field before the byte itself is handled.
	logic [2:0]  phase_cur;
	logic [3:0]  counter_cur;
	logic [7:0]  crc_cur;
	logic [31:0] shift_cur;
	logic        value_good_cur;
	logic        frame_good_cur;
	logic        frame_done_cur;

	logic [2:0]  phase_nxt;
	logic [3:0]  counter_nxt;
	logic [7:0]  crc_nxt;
	logic [31:0] shift_nxt;
	logic        value_good_nxt;
	logic        frame_good_nxt;
	logic        frame_done_nxt;

	logic [7:0]  b;
	logic        crc_match;
	logic [3:0]  count_eff;
	logic [4:0]  counter_inc;
	logic        is_last;
	out_t        result;

	assign b = item_s1.rx_byte;

	always_comb begin
		if (item_s1.frame_start) begin
			phase_cur      = PH_DATA0_A;
			counter_cur    = 4'd0;
			crc_cur        = CRC_INIT;
			shift_cur      = 32'd0;
			value_good_cur = 1'b1;
			frame_good_cur = 1'b1;
			frame_done_cur = 1'b0;
		end else begin
			phase_cur      = phase_q;
			counter_cur    = counter_q;
			crc_cur        = crc_q;
			shift_cur      = shift_q;
			value_good_cur = value_good_q;
			frame_good_cur = frame_good_q;
			frame_done_cur = frame_done_q;
		end
	end

	// Clamp the configured count into 1 .. MAX_VALUES.
	always_comb begin
		if (value_count_q == 4'd0) begin
			count_eff = 4'd1;
		end else if (value_count_q > VALUE_COUNT_MAX) begin
			count_eff = VALUE_COUNT_MAX;
		end else begin
			count_eff = value_count_q;
		end
	end

	assign crc_match   = (crc_cur == b);
	assign counter_inc = {1'b0, counter_cur} + 5'd1;
	assign is_last     = counter_inc >= {1'b0, count_eff};

	always_comb begin
		phase_nxt      = phase_cur;
		counter_nxt    = counter_cur;
		crc_nxt        = crc_cur;
		shift_nxt      = shift_cur;
		value_good_nxt = value_good_cur;
		frame_good_nxt = frame_good_cur;
		frame_done_nxt = frame_done_cur;
		emit           = 1'b0;

		result.value_index = counter_cur;
		result.value       = shift_cur;
		result.words_ok    = value_good_cur && crc_match;
		result.frame_ok    = frame_good_cur && crc_match;
		result.last        = is_last;

		// Idle: drop the byte.
		if (valid_s1 && !frame_done_cur) begin
			case (phase_cur)
				PH_DATA0_A, PH_DATA0_B: begin
					crc_nxt   = crc8_byte(CRC_INIT, b);
					shift_nxt = {shift_cur[23:0], b};
					phase_nxt = phase_cur + 3'd1;
				end
				PH_DATA1_A, PH_DATA1_B: begin
					crc_nxt   = crc8_byte(crc_cur, b);
					shift_nxt = {shift_cur[23:0], b};
					phase_nxt = phase_cur + 3'd1;
				end
				PH_CRC_A: begin
					if (!crc_match) begin
						value_good_nxt = 1'b0;
						frame_good_nxt = 1'b0;
					end
					phase_nxt = PH_DATA0_B;
				end
				default: begin
					// Second CRC byte: the value is complete.
					emit           = 1'b1;
					if (!crc_match) begin
						frame_good_nxt = 1'b0;
					end
					counter_nxt    = counter_inc[3:0];
					phase_nxt      = PH_DATA0_A;
					crc_nxt        = CRC_INIT;
					shift_nxt      = 32'd0;
					value_good_nxt = 1'b1;
					if (is_last) begin
						frame_done_nxt = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DATA0_A;
			counter_q    <= 4'd0;
			crc_q        <= CRC_INIT;
			shift_q      <= 32'd0;
			value_good_q <= 1'b1;
			frame_good_q <= 1'b1;
			frame_done_q <= 1'b1;
		end else if (advance_s1) begin
			phase_q      <= phase_nxt;
			counter_q    <= counter_nxt;
			crc_q        <= crc_nxt;
			shift_q      <= shift_nxt;
			value_good_q <= value_good_nxt;
			frame_good_q <= frame_good_nxt;
			frame_done_q <= frame_done_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic out_valid_q;
	out_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

// ----- tb/tb_crc_checked_word_pair_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_crc_checked_word_pair_deframer
// Self-checking bench for the CRC-8 triplet deframer: feeds framed byte
// streams (clean, corrupted, cut short, with stray bytes) under random
// back-pressure and compares every emitted 32-bit value against a predictor.
// ----------------------------------------------------------------------------
module tb_crc_checked_word_pair_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	import cwpd_pkg::*;

	localparam int ITEM_TARGET  = 1300;   // frame bytes in the random part
	localparam int CALM_ITEMS   = 200;    // final stretch without any stalls
	localparam int DRAIN_CYCLES = 4;      // two-stage pipeline plus margin
	localparam logic [3:0] CORNER_COUNTS [5] = '{4'd0, 4'd15, 4'd1, 4'd10, 4'd11};

	// ------------------------------------------------------------------------
	// Scoreboard: tracks the deframer state byte by byte and queues the
	// values it must emit, then matches them in order against the outputs.
	// ------------------------------------------------------------------------
	class triplet_scoreboard;
		logic [3:0]  count_reg;
		logic [2:0]  phase;
		logic [3:0]  index;
		logic [7:0]  crc;
		logic [31:0] shift;
		bit          value_good;
		bit          frame_good;
		bit          idle;
		out_t        expected_values[$];
		int          errors;

		function new();
			count_reg = VALUE_COUNT_RESET;
			open_frame();
			idle = 1'b1;
			errors = 0;
		endfunction

		function void open_frame();
			phase = PH_DATA0_A;
			index = '0;
			crc = CRC_INIT;
			shift = '0;
			value_good = 1'b1;
			frame_good = 1'b1;
			idle = 1'b0;
		endfunction

		function logic [7:0] crc8(logic [7:0] seed, logic [7:0] b);
			logic [7:0] c;
			c = seed ^ b;
			repeat (8) c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
			return c;
		endfunction

		function void set_count(logic [3:0] v);
			count_reg = v;
		endfunction

		function int pending();
			return expected_values.size();
		endfunction

		// Advance the deframer by one accepted byte.
		function void note_byte(in_t item);
			out_t e;
			int   lim;
			if (item.frame_start) open_frame();
			if (idle) return;
			case (phase)
				PH_DATA0_A, PH_DATA0_B: begin
					crc = crc8(CRC_INIT, item.rx_byte);
					shift = {shift[23:0], item.rx_byte};
					phase = phase + 3'd1;
				end
				PH_DATA1_A, PH_DATA1_B: begin
					crc = crc8(crc, item.rx_byte);
					shift = {shift[23:0], item.rx_byte};
					phase = phase + 3'd1;
				end
				PH_CRC_A: begin
					if (crc != item.rx_byte) begin
						value_good = 1'b0;
						frame_good = 1'b0;
					end
					phase = PH_DATA0_B;
				end
				default: begin
					if (crc != item.rx_byte) begin
						value_good = 1'b0;
						frame_good = 1'b0;
					end
					lim = (count_reg == 0) ? 1 :
						(count_reg > VALUE_COUNT_MAX) ? int'(VALUE_COUNT_MAX) : int'(count_reg);
					e.value_index = index;
					e.value = shift;
					e.words_ok = value_good;
					e.frame_ok = frame_good;
					e.last = (int'(index) + 1 >= lim);
					expected_values.push_back(e);
					index = index + 4'd1;
					phase = PH_DATA0_A;
					crc = CRC_INIT;
					shift = '0;
					value_good = 1'b1;
					if (e.last) idle = 1'b1;
				end
			endcase
		endfunction

		function void report(string what, out_t e, out_t g);
			errors++;
			if (errors <= 10) begin
				$display("%s: exp idx=%0d val=%08h wok=%b fok=%b last=%b | got idx=%0d val=%08h wok=%b fok=%b last=%b",
					what, e.value_index, e.value, e.words_ok, e.frame_ok, e.last,
					g.value_index, g.value, g.words_ok, g.frame_ok, g.last);
			end
		endfunction

		function void check_value(out_t got);
			out_t e;
			if (expected_values.size() == 0) begin
				report("unexpected value", '0, got);
				return;
			end
			e = expected_values.pop_front();
			if (got.value_index !== e.value_index || got.value !== e.value ||
					got.words_ok !== e.words_ok || got.frame_ok !== e.frame_ok ||
					got.last !== e.last) begin
				report("value mismatch", e, got);
			end
		endfunction

		function void flush();
			if (expected_values.size() != 0) begin
				$display("%0d expected values never emitted", expected_values.size());
				errors += expected_values.size();
				expected_values.delete();
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	triplet_scoreboard sb;
	bit calm = 1'b0;      // set for the final stretch: no gaps, no stalls
	bit gaps_on = 1'b0;   // per-frame switch for sender gaps
	int stall_left = 0;
	int run_left = 0;

	crc_checked_word_pair_deframer dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop in case the pipeline hangs.
	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Feed the predictor on every accepted input transaction; check every
	// accepted output transaction against the oldest queued value.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_byte(in_data);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_value(out_data);
	end

	// Receiver back-pressure: alternate ready runs with stall bursts; hold
	// ready high once the run goes calm.
	always @(negedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (run_left > 0) begin
			out_ready <= 1'b1;
			run_left <= run_left - 1;
		end else if ($urandom_range(0, 2) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(1, 9) - 1;
		end else begin
			out_ready <= 1'b1;
			run_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 24);
		end
	end

	// Present one byte and hold it until the transaction completes. Valid
	// stays high between back-to-back bytes; drop it only for a gap.
	task automatic send_byte(input logic [7:0] b, input logic start);
		@(negedge clk);
		if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data.rx_byte <= b;
		in_data.frame_start <= start;
		do @(posedge clk); while (!in_ready);
	endtask

	// Send up to three bytes of a data, data, crc triplet.
	task automatic send_triplet(input logic [7:0] hi, input logic [7:0] lo, input bit corrupt,
			input logic start, input int nbytes = 3);
		logic [7:0] chk;
		chk = sb.crc8(sb.crc8(CRC_INIT, hi), lo);
		if (corrupt) chk = chk ^ (8'h01 << $urandom_range(0, 7));
		if (nbytes > 0) send_byte(hi, start);
		if (nbytes > 1) send_byte(lo, 1'b0);
		if (nbytes > 2) send_byte(chk, 1'b0);
	endtask

	// Send the first n_bytes of a frame of random triplets; corrupt a
	// triplet CRC with odds 1 in bad_odds (0 keeps the frame clean).
	task automatic send_frame(input int n_bytes, input int bad_odds);
		int  left;
		bit  first;
		left = n_bytes;
		first = 1'b1;
		while (left > 0) begin
			send_triplet(8'($urandom), 8'($urandom),
				bad_odds != 0 && $urandom_range(1, bad_odds) == 1, first, (left < 3) ? left : 3);
			left -= 3;
			first = 1'b0;
		end
	endtask

	// Drop valid and wait until every queued value has been emitted, then
	// let the pipeline empty out behind bytes that produce no value.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Two-phase register write: setup cycle, then access cycle.
	task automatic write_count(input logic [3:0] v);
		logic [31:0] word;
		word = $urandom;
		word[3:0] = v;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_VALUE_COUNT, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_count(v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		int fed;
		int round;
		int n;
		int cut;
		logic [3:0] cfg;

		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. A byte without frame start after reset is ignored.
		send_byte(8'hA5, 1'b0);
		settle();
		write_count(4'd1);
		// Clean single-value frame with all-zero then all-one data.
		send_triplet(8'h00, 8'h00, 1'b0, 1'b1);
		send_triplet(8'hFF, 8'hFF, 1'b0, 1'b0);
		// Stray byte after the last value: ignored.
		send_byte(8'h5A, 1'b0);
		// Bad CRC on the first triplet.
		send_triplet(8'hFF, 8'hFF, 1'b1, 1'b1);
		send_triplet(8'h00, 8'h00, 1'b0, 1'b0);
		// Restart mid-value drops the partial value; then bad CRC on the
		// second triplet.
		send_triplet(8'h12, 8'h34, 1'b0, 1'b1);
		send_triplet(8'hAB, 8'hCD, 1'b0, 1'b1);
		send_triplet(8'hEF, 8'h01, 1'b1, 1'b0);

		// Random part: rounds of frames, each under a fresh value count.
		fed = 0;
		round = 0;
		while (fed < ITEM_TARGET) begin
			cfg = (round < 5) ? CORNER_COUNTS[round] : 4'($urandom_range(0, 15));
			settle();
			write_count(cfg);
			n = (cfg == 0) ? 1 : (cfg > VALUE_COUNT_MAX) ? int'(VALUE_COUNT_MAX) : int'(cfg);
			repeat ($urandom_range(2, 5)) begin
				calm = (fed >= ITEM_TARGET - CALM_ITEMS);
				gaps_on = ($urandom_range(0, 3) != 0);
				// Mostly whole frames; now and then cut one short so the
				// next frame start lands mid-value.
				cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6 * n - 1) : 6 * n;
				send_frame(cut, $urandom_range(0, 1) ? 0 : 5);
				fed += cut;
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
				end
			end
			round++;
		end

		settle();
		sb.flush();
		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/cwpd_pkg.sv
hw/rtl/crc_checked_word_pair_deframer.sv
tb/tb_crc_checked_word_pair_deframer.sv
